@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the record deframer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, ignored while reset is high.
`define LPRD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, also checked during reset.
`define LPRD_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

@@ rtl/lprd_pkg.sv @@
// Package for the length-prefixed record deframer: types, codes, constants.
// No dependencies; used by lprd_parse, lprd_rsp_fifo and the top level.
`default_nettype none

package lprd_pkg;

   localparam int MAX_LEN_DIGITS = 5;
   localparam int PREFIX_LEN     = 10;
   localparam int RSP_DEPTH      = 4;

   localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
   localparam logic [15:0] TOTAL_MAX     = 16'hFFFF;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_DROP    = 2'd2,
      KIND_SUMMARY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_DIGITS  = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_CR      = 3'd3,
      PH_LF      = 3'd4
   } phase_type;

   typedef struct packed {
      kind_type    item_kind;
      logic [7:0]  payload_byte;
      logic [15:0] total_len;
      logic        success;
      logic        run_last;
   } result_type;

   // Up to two results per item: the phase result and the end summary.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // Characters of "+HTTPCGET:".
   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h2B;
         4'd1:    c = 8'h48;
         4'd2:    c = 8'h54;
         4'd3:    c = 8'h54;
         4'd4:    c = 8'h50;
         4'd5:    c = 8'h43;
         4'd6:    c = 8'h47;
         4'd7:    c = 8'h45;
         4'd8:    c = 8'h54;
         4'd9:    c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lprd_parse.sv @@
// Per-byte record parser: phase state, length field, running total.
// Uses lprd_pkg; produces up to two results per accepted item.
`default_nettype none

module lprd_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_accept,
   input  wire logic [7:0]         data_byte,
   input  wire logic               end_of_response,
   input  wire logic [15:0]        max_record_len,
   output lprd_pkg::push_type      push
);

   lprd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  prefix_index_ff, prefix_index_in;
   logic [16:0] declared_len_ff, declared_len_in;
   logic [2:0]  digit_count_ff, digit_count_in;
   logic [16:0] bytes_left_ff, bytes_left_in;
   logic [15:0] accepted_total_ff, accepted_total_in;

   logic        restart;
   logic        do_hunt;
   logic [3:0]  hunt_base;
   logic [3:0]  hunt_idx;
   logic        hunt_found;
   logic [3:0]  hunt_next;
   logic        is_digit;
   logic [3:0]  digit_val;
   logic [19:0] len_times_ten;
   logic [16:0] bytes_dec;
   logic [17:0] total_sum;
   logic        main_valid;
   lprd_pkg::kind_type main_kind;
   lprd_pkg::result_type main_res, sum_res;

   assign is_digit  = (data_byte >= lprd_pkg::CHAR_ZERO) && (data_byte <= lprd_pkg::CHAR_NINE);
   assign digit_val = 4'(data_byte - lprd_pkg::CHAR_ZERO);
   assign len_times_ten = {declared_len_ff, 3'b000} + 20'({declared_len_ff, 1'b0})
                          + 20'(digit_val);
   assign bytes_dec = (bytes_left_ff == 17'd0) ? 17'd0 : bytes_left_ff - 17'd1;
   assign total_sum = 18'(accepted_total_ff) + 18'(declared_len_ff);

   // Prefix matcher; a restart hunts from the first character again
   assign hunt_base = restart ? 4'd0 : prefix_index_ff;
   assign hunt_idx  = (hunt_base >= 4'(lprd_pkg::PREFIX_LEN)) ? 4'd0 : hunt_base;

   always_comb begin
      hunt_found = 1'b0;
      if (data_byte == lprd_pkg::prefix_char(hunt_idx)) begin
         if (hunt_idx == 4'(lprd_pkg::PREFIX_LEN - 1)) begin
            hunt_found = 1'b1;
            hunt_next  = 4'd0;
         end else begin
            hunt_next = hunt_idx + 4'd1;
         end
      end else begin
         hunt_next = (data_byte == lprd_pkg::CHAR_PLUS) ? 4'd1 : 4'd0;
      end
   end

   // Next state
   always_comb begin
      phase_in          = phase_ff;
      prefix_index_in   = prefix_index_ff;
      declared_len_in   = declared_len_ff;
      digit_count_in    = digit_count_ff;
      bytes_left_in     = bytes_left_ff;
      accepted_total_in = accepted_total_ff;
      restart    = 1'b0;
      do_hunt    = 1'b0;
      main_valid = 1'b0;
      main_kind  = lprd_pkg::KIND_DROP;

      unique case (phase_ff)
         lprd_pkg::PH_HUNT: begin
            do_hunt = 1'b1;
         end
         lprd_pkg::PH_DIGITS: begin
            if (is_digit) begin
               if (digit_count_ff >= 3'(lprd_pkg::MAX_LEN_DIGITS)) begin
                  restart = 1'b1;
               end else begin
                  declared_len_in = len_times_ten[16:0];
                  digit_count_in  = digit_count_ff + 3'd1;
               end
            end else if (data_byte == lprd_pkg::CHAR_COMMA && digit_count_ff != 3'd0) begin
               if (declared_len_ff > {1'b0, max_record_len}) begin
                  main_valid      = 1'b1;
                  phase_in        = lprd_pkg::PH_HUNT;
                  prefix_index_in = 4'd0;
               end else begin
                  bytes_left_in = declared_len_ff;
                  phase_in = (declared_len_ff == 17'd0) ? lprd_pkg::PH_CR
                                                        : lprd_pkg::PH_PAYLOAD;
               end
            end else begin
               restart = 1'b1;
            end
         end
         lprd_pkg::PH_PAYLOAD: begin
            main_valid    = 1'b1;
            main_kind     = lprd_pkg::KIND_BYTE;
            bytes_left_in = bytes_dec;
            if (bytes_dec == 17'd0) begin
               phase_in = lprd_pkg::PH_CR;
            end
         end
         lprd_pkg::PH_CR: begin
            if (data_byte == lprd_pkg::CHAR_CR) begin
               phase_in = lprd_pkg::PH_LF;
            end else begin
               main_valid = 1'b1;
               restart    = 1'b1;
            end
         end
         lprd_pkg::PH_LF: begin
            main_valid = 1'b1;
            if (data_byte == lprd_pkg::CHAR_LF) begin
               main_kind = lprd_pkg::KIND_ACCEPT;
               accepted_total_in = total_sum[17:16] != 2'b00 ? lprd_pkg::TOTAL_MAX
                                                              : total_sum[15:0];
               phase_in        = lprd_pkg::PH_HUNT;
               prefix_index_in = 4'd0;
            end else begin
               restart = 1'b1;
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      if (restart || do_hunt) begin
         phase_in        = hunt_found ? lprd_pkg::PH_DIGITS : lprd_pkg::PH_HUNT;
         prefix_index_in = hunt_next;
         if (hunt_found) begin
            declared_len_in = 17'd0;
            digit_count_in  = 3'd0;
         end
      end
   end

   // Results
   always_comb begin
      main_res.item_kind    = main_kind;
      main_res.payload_byte = (main_kind == lprd_pkg::KIND_BYTE) ? data_byte : 8'd0;
      main_res.total_len    = accepted_total_in;
      main_res.success      = 1'b0;
      main_res.run_last     = !end_of_response;

      sum_res.item_kind    = lprd_pkg::KIND_SUMMARY;
      sum_res.payload_byte = 8'd0;
      sum_res.total_len    = accepted_total_in;
      sum_res.success      = (accepted_total_in != 16'd0);
      sum_res.run_last     = 1'b1;

      push.count  = in_accept ? (2'(main_valid) + 2'(end_of_response)) : 2'd0;
      push.first  = main_valid ? main_res : sum_res;
      push.second = sum_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= lprd_pkg::PH_HUNT;
         prefix_index_ff   <= 4'd0;
         declared_len_ff   <= 17'd0;
         digit_count_ff    <= 3'd0;
         bytes_left_ff     <= 17'd0;
         accepted_total_ff <= 16'd0;
      end else if (in_accept) begin
         if (end_of_response) begin
            // summary given; start afresh
            phase_ff          <= lprd_pkg::PH_HUNT;
            prefix_index_ff   <= 4'd0;
            declared_len_ff   <= 17'd0;
            digit_count_ff    <= 3'd0;
            bytes_left_ff     <= 17'd0;
            accepted_total_ff <= 16'd0;
         end else begin
            phase_ff          <= phase_in;
            prefix_index_ff   <= prefix_index_in;
            declared_len_ff   <= declared_len_in;
            digit_count_ff    <= digit_count_in;
            bytes_left_ff     <= bytes_left_in;
            accepted_total_ff <= accepted_total_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/lprd_rsp_fifo.sv @@
// Result queue: takes up to two results a cycle, delivers one a cycle while out_ready is high.
// Uses lprd_pkg for the result and push types.
`default_nettype none

module lprd_rsp_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lprd_pkg::push_type   push,
   output logic                      space_ok,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output lprd_pkg::result_type      out_res
);

   localparam int PTR_W = $clog2(lprd_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(lprd_pkg::RSP_DEPTH + 1);

   lprd_pkg::result_type mem_ff [lprd_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   // Room for both results of one item regardless of the output side
   assign space_ok  = (count_ff <= CNT_W'(lprd_pkg::RSP_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/length_prefixed_record_deframer_top.sv @@
// Channel  Direction  Payload
// req      in         data_byte[7:0], end_of_response
// rsp      out        item_kind[1:0], payload_byte[7:0], total_len[15:0], success, run_last
// csr      in         max_record_len[15:0] (write only)
//
// One input item per cycle while req_ready is high; its results enter a 4-entry result queue the same cycle.
// An item yields 0, 1 or 2 results; the output side delivers one per cycle while rsp_ready is high.
// req_ready is low while the queue has fewer than two free entries.
// Synchronous reset clears parser state and queue; max_record_len returns to 4096.
// Depends on lprd_pkg, lprd_parse, lprd_rsp_fifo and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module length_prefixed_record_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_response,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_item_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [15:0]      rsp_total_len,
   output logic             rsp_success,
   output logic             rsp_run_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   logic [15:0]          max_len_ff;
   logic                 req_accept;
   logic                 space_ok;
   lprd_pkg::push_type   push;
   lprd_pkg::result_type head;

   assign csr_ready  = 1'b1;
   assign req_ready  = space_ok;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lprd_pkg::MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   lprd_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (req_accept),
      .data_byte       (req_data_byte),
      .end_of_response (req_end_of_response),
      .max_record_len  (max_len_ff),
      .push            (push)
   );

   lprd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (head)
   );

   assign rsp_item_kind    = head.item_kind;
   assign rsp_payload_byte = head.payload_byte;
   assign rsp_total_len    = head.total_len;
   assign rsp_success      = head.success;
   assign rsp_run_last     = head.run_last;

   `LPRD_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)
   `LPRD_ASSERT_IMP(a_summary_last, clock, reset,
      rsp_valid && rsp_item_kind == lprd_pkg::KIND_SUMMARY, rsp_run_last)
   `LPRD_ASSERT_IMP(a_success_summary, clock, reset,
      rsp_valid && rsp_success, rsp_item_kind == lprd_pkg::KIND_SUMMARY)
   `LPRD_ASSERT_IMP(a_byte_kind, clock, reset,
      rsp_valid && rsp_payload_byte != 8'd0, rsp_item_kind == lprd_pkg::KIND_BYTE)

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for length_prefixed_record_deframer_top: a short directed table, then random
// record streams under several length limits, checked against an in-bench deframer (typed rows against the table).
// Depends on lprd_pkg and the deframer RTL.

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 250;
   localparam int PHASE_ITEMS    = 175;
   localparam int MAX_REPORTS    = 40;
   localparam logic [79:0] HDR   = "+HTTPCGET:";

   typedef struct packed {
      logic [7:0]         b;
      logic               eor;
      logic               typed;
      lprd_pkg::kind_type k;
      logic [15:0]        tot;
      logic               succ;
   } dir_row_type;

   typedef struct {
      int                 seq;
      lprd_pkg::kind_type k;
      logic [15:0]        tot;
      logic               succ;
   } typed_note_type;

   // Directed items; typed rows carry the last result that the item must give.
   localparam int N_ROWS = 18;
   localparam dir_row_type DIR_ROWS [N_ROWS] = '{
      '{8'h00,                1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{8'hFF,                1'b1, 1'b1, lprd_pkg::KIND_SUMMARY, 16'd0, 1'b0},
      '{lprd_pkg::CHAR_PLUS,  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{lprd_pkg::CHAR_PLUS,  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"H",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"T",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"T",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"P",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"C",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"G",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"E",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{"T",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{":",                  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{lprd_pkg::CHAR_ZERO,  1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{lprd_pkg::CHAR_COMMA, 1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{lprd_pkg::CHAR_CR,    1'b0, 1'b0, lprd_pkg::KIND_BYTE,    16'd0, 1'b0},
      '{lprd_pkg::CHAR_LF,    1'b0, 1'b1, lprd_pkg::KIND_ACCEPT,  16'd0, 1'b0},
      '{lprd_pkg::CHAR_PLUS,  1'b1, 1'b1, lprd_pkg::KIND_SUMMARY, 16'd0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_response;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_item_kind;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_total_len;
   logic        rsp_success;
   logic        rsp_run_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   length_prefixed_record_deframer_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_response (req_end_of_response),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_item_kind       (rsp_item_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_total_len       (rsp_total_len),
      .rsp_success         (rsp_success),
      .rsp_run_last        (rsp_run_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Deframer state as the bench sees it
   lprd_pkg::phase_type m_phase;
   logic [3:0]  m_idx;
   logic [16:0] m_len;
   logic [2:0]  m_digits;
   logic [16:0] m_left;
   logic [15:0] m_total;
   logic [15:0] m_max;

   lprd_pkg::result_type step_out [2];
   int          step_n;
   lprd_pkg::result_type pending_results [$];
   typed_note_type typed_notes [$];
   int          taken_items = 0;
   int          errors = 0;
   int          quiet = 0;

   logic [8:0]  byte_stream [$];
   int          eor_chance;
   bit          burst;

   function automatic logic [7:0] hdr_char(input int i);
      return HDR[79 - 8 * i -: 8];
   endfunction

   task automatic clear_model(input logic with_reg);
      m_phase  = lprd_pkg::PH_HUNT;
      m_idx    = '0;
      m_len    = '0;
      m_digits = '0;
      m_left   = '0;
      m_total  = '0;
      if (with_reg)
         m_max = lprd_pkg::MAX_LEN_RESET;
   endtask

   task automatic hunt_char(input logic [7:0] b);
      if (m_idx >= lprd_pkg::PREFIX_LEN)
         m_idx = '0;
      if (b == hdr_char(m_idx)) begin
         m_idx = m_idx + 4'd1;
         if (m_idx == lprd_pkg::PREFIX_LEN) begin
            m_phase  = lprd_pkg::PH_DIGITS;
            m_idx    = '0;
            m_len    = '0;
            m_digits = '0;
         end
      end else begin
         m_idx = (b == lprd_pkg::CHAR_PLUS) ? 4'd1 : 4'd0;
      end
   endtask

   task automatic rehunt(input logic [7:0] b);
      m_phase = lprd_pkg::PH_HUNT;
      m_idx   = '0;
      hunt_char(b);
   endtask

   task automatic emit(input lprd_pkg::kind_type k, input logic [7:0] pb, input logic s);
      step_out[step_n].item_kind    = k;
      step_out[step_n].payload_byte = pb;
      step_out[step_n].total_len    = m_total;
      step_out[step_n].success      = s;
      step_out[step_n].run_last     = 1'b0;
      step_n++;
   endtask

   // Advances the deframer by one byte; results land in step_out[0 .. step_n-1].
   task automatic deframe_byte(input logic [7:0] b, input logic e);
      logic [17:0] sum;
      step_n = 0;
      case (m_phase)
         lprd_pkg::PH_HUNT: hunt_char(b);
         lprd_pkg::PH_DIGITS: begin
            if (b >= lprd_pkg::CHAR_ZERO && b <= lprd_pkg::CHAR_NINE) begin
               if (m_digits >= lprd_pkg::MAX_LEN_DIGITS) begin
                  rehunt(b);
               end else begin
                  m_len    = 17'(m_len * 10 + (b - lprd_pkg::CHAR_ZERO));
                  m_digits = m_digits + 3'd1;
               end
            end else if (b == lprd_pkg::CHAR_COMMA && m_digits > 0) begin
               if (m_len > {1'b0, m_max}) begin
                  emit(lprd_pkg::KIND_DROP, 8'h00, 1'b0);
                  m_phase = lprd_pkg::PH_HUNT;
                  m_idx   = '0;
               end else begin
                  m_left = m_len;
                  if (m_left == 0)
                     m_phase = lprd_pkg::PH_CR;
                  else
                     m_phase = lprd_pkg::PH_PAYLOAD;
               end
            end else begin
               rehunt(b);
            end
         end
         lprd_pkg::PH_PAYLOAD: begin
            emit(lprd_pkg::KIND_BYTE, b, 1'b0);
            if (m_left > 0)
               m_left = m_left - 17'd1;
            if (m_left == 0)
               m_phase = lprd_pkg::PH_CR;
         end
         lprd_pkg::PH_CR: begin
            if (b == lprd_pkg::CHAR_CR) begin
               m_phase = lprd_pkg::PH_LF;
            end else begin
               emit(lprd_pkg::KIND_DROP, 8'h00, 1'b0);
               rehunt(b);
            end
         end
         lprd_pkg::PH_LF: begin
            if (b == lprd_pkg::CHAR_LF) begin
               sum     = m_total + m_len;
               m_total = (sum > lprd_pkg::TOTAL_MAX) ? lprd_pkg::TOTAL_MAX : sum[15:0];
               emit(lprd_pkg::KIND_ACCEPT, 8'h00, 1'b0);
               m_phase = lprd_pkg::PH_HUNT;
               m_idx   = '0;
            end else begin
               emit(lprd_pkg::KIND_DROP, 8'h00, 1'b0);
               rehunt(b);
            end
         end
         default: rehunt(b);
      endcase
      if (e) begin
         emit(lprd_pkg::KIND_SUMMARY, 8'h00, m_total != 0);
         clear_model(1'b0);
      end
   endtask

   task automatic take_item(input logic [7:0] b, input logic e);
      typed_note_type note;
      deframe_byte(b, e);
      if (typed_notes.size() > 0 && typed_notes[0].seq == taken_items) begin
         note = typed_notes.pop_front();
         if (step_n == 0)
            step_n = 1;
         step_out[step_n - 1].item_kind    = note.k;
         step_out[step_n - 1].payload_byte = 8'h00;
         step_out[step_n - 1].total_len    = note.tot;
         step_out[step_n - 1].success      = note.succ;
      end
      for (int i = 0; i < step_n; i++) begin
         step_out[i].run_last = (i == step_n - 1);
         pending_results.push_back(step_out[i]);
      end
      taken_items++;
   endtask

   task automatic report(input string what, input int want, input int got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic check_result();
      lprd_pkg::result_type want;
      if (pending_results.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: result with none expected, expected none, got kind %0d byte %0d",
                     $time, rsp_item_kind, rsp_payload_byte);
      end else begin
         want = pending_results.pop_front();
         if (rsp_item_kind != want.item_kind)
            report("item_kind", want.item_kind, rsp_item_kind);
         if (rsp_payload_byte != want.payload_byte)
            report("payload_byte", want.payload_byte, rsp_payload_byte);
         if (rsp_total_len != want.total_len)
            report("total_len", want.total_len, rsp_total_len);
         if (rsp_success != want.success)
            report("success", want.success, rsp_success);
         if (rsp_run_last != want.run_last)
            report("run_last", want.run_last, rsp_run_last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model(1'b1);
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            take_item(req_data_byte, req_end_of_response);
         if (csr_valid && csr_ready)
            m_max = csr_data;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Mostly short idle stretches, a few long ones.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int ndig(input int value);
      int n;
      int v;
      n = 1;
      v = value;
      while (v >= 10) begin
         v = v / 10;
         n++;
      end
      return n;
   endfunction

   // ---------------- stimulus building ----------------

   task automatic put_byte(input logic [7:0] b);
      logic e;
      e = (eor_chance > 0) && ($urandom_range(1, eor_chance) == 1);
      byte_stream.push_back({e, b});
   endtask

   task automatic put_header();
      for (int i = 0; i < lprd_pkg::PREFIX_LEN; i++)
         put_byte(hdr_char(i));
   endtask

   task automatic put_len(input int value, input int width);
      logic [7:0] dig [6];
      int v;
      v = value;
      for (int k = 0; k < width; k++) begin
         dig[k] = lprd_pkg::CHAR_ZERO + 8'(v % 10);
         v = v / 10;
      end
      for (int k = width - 1; k >= 0; k--)
         put_byte(dig[k]);
   endtask

   task automatic put_payload(input int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0)
            put_byte(lprd_pkg::CHAR_PLUS);
         else if (r == 1)
            put_byte(lprd_pkg::CHAR_CR);
         else
            put_byte(8'($urandom_range(0, 255)));
      end
   endtask

   function automatic int pick_len(input int lim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(0, (lim < 6) ? lim : 6);
      if (r < 85 && lim <= 40)
         return $urandom_range((lim > 0) ? lim - 1 : 0, lim);
      return $urandom_range(0, (lim < 40) ? lim : 40);
   endfunction

   function automatic int pick_width(input int len);
      int w;
      w = ndig(len);
      if ($urandom_range(0, 3) == 0)
         w = w + $urandom_range(0, lprd_pkg::MAX_LEN_DIGITS - w);
      return w;
   endfunction

   task automatic add_chunk(input int lim);
      int r;
      int len;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         // well-formed record
         len = pick_len(lim);
         put_header();
         put_len(len, pick_width(len));
         put_byte(lprd_pkg::CHAR_COMMA);
         put_payload(len);
         put_byte(lprd_pkg::CHAR_CR);
         put_byte(lprd_pkg::CHAR_LF);
      end else if (r < 58) begin
         // declared length above the limit
         len = $urandom_range(lim + 1, 99999);
         put_header();
         put_len(len, pick_width(len));
         put_byte(lprd_pkg::CHAR_COMMA);
         put_payload($urandom_range(0, 3));
      end else if (r < 64) begin
         // one digit too many
         put_header();
         put_len($urandom_range(0, 999999), lprd_pkg::MAX_LEN_DIGITS + 1);
         put_byte(lprd_pkg::CHAR_COMMA);
      end else if (r < 72) begin
         // malformed length field
         put_header();
         case ($urandom_range(0, 4))
            0: put_byte(" ");
            1: put_byte(lprd_pkg::CHAR_PLUS);
            2: put_byte("-");
            3: put_byte(lprd_pkg::CHAR_COMMA);
            default: put_byte(8'($urandom_range(0, 255)));
         endcase
         if ($urandom_range(0, 1) == 1) begin
            put_len($urandom_range(0, 9), 1);
            put_byte(lprd_pkg::CHAR_COMMA);
         end
      end else if (r < 80) begin
         // prefix broken partway
         len = $urandom_range(1, lprd_pkg::PREFIX_LEN - 1);
         for (int i = 0; i < len; i++)
            put_byte(hdr_char(i));
         put_byte(($urandom_range(0, 1) == 1) ? lprd_pkg::CHAR_PLUS
                                                : 8'($urandom_range(0, 255)));
      end else if (r < 90) begin
         // bad trailer after the payload
         len = pick_len(lim);
         put_header();
         put_len(len, ndig(len));
         put_byte(lprd_pkg::CHAR_COMMA);
         put_payload(len);
         b = ($urandom_range(0, 1) == 1) ? lprd_pkg::CHAR_PLUS : 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 1) begin
            if (b == lprd_pkg::CHAR_CR)
               b = lprd_pkg::CHAR_PLUS;
            put_byte(b);
         end else begin
            if (b == lprd_pkg::CHAR_LF)
               b = lprd_pkg::CHAR_PLUS;
            put_byte(lprd_pkg::CHAR_CR);
            put_byte(b);
         end
      end else begin
         put_payload($urandom_range(1, 6));
      end
   endtask

   // Forces end of response on the last queued item.
   task automatic close_stream();
      logic [8:0] last;
      last = byte_stream.pop_back();
      byte_stream.push_back({1'b1, last[7:0]});
   endtask

   // ---------------- driving ----------------

   task automatic send_byte(input logic [7:0] b, input logic e);
      int g;
      g = burst ? 0 : idle_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data_byte       <= b;
      req_end_of_response <= e;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_stream();
      logic [8:0] v;
      while (byte_stream.size() > 0) begin
         if ($urandom_range(0, 39) == 0)
            burst = ($urandom_range(0, 3) == 0);
         v = byte_stream.pop_front();
         send_byte(v[7:0], v[8]);
      end
      req_valid <= 1'b0;
   endtask

   // Limit writes wait for the block to drain.
   task automatic write_max(input logic [15:0] value);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_max [6];
      int sent;
      typed_note_type note;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_data_byte       = '0;
      req_end_of_response = 1'b0;
      csr_valid           = 1'b0;
      csr_data            = '0;
      burst               = 1'b0;
      eor_chance          = 80;
      sent                = 0;
      phase_max = '{4096, 0, 65535, 3, $urandom_range(1, 30), 12};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         if (DIR_ROWS[i].typed) begin
            note.seq  = sent;
            note.k    = DIR_ROWS[i].k;
            note.tot  = DIR_ROWS[i].tot;
            note.succ = DIR_ROWS[i].succ;
            typed_notes.push_back(note);
         end
         send_byte(DIR_ROWS[i].b, DIR_ROWS[i].eor);
         sent++;
      end

      // First random phase runs at the reset limit.
      for (int p = 0; p < 6; p++) begin
         if (p > 0)
            write_max(16'(phase_max[p]));
         while (byte_stream.size() < PHASE_ITEMS)
            add_chunk(phase_max[p]);
         close_stream();
         send_stream();
      end

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Result side: random ready, plus one long hold-off that backs up the input.
   initial begin
      int run;
      int stall;
      bit held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!held && taken_items >= 500) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = idle_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

endmodule
